/* hw/rtl/ftdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ftdc_pkg
// Shared widths, constants and register indexes of the thermostat core.
// ---------------------------------------------------------------------------
package ftdc_pkg;

    localparam int SOH_W = 12;
    localparam logic [SOH_W-1:0] SECONDS_PER_HOUR = 12'd3600;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRIDGE_SETPOINT        = 3'd0,
        REG_FRIDGE_BAND            = 3'd1,
        REG_FREEZER_SETPOINT       = 3'd2,
        REG_FREEZER_BAND           = 3'd3,
        REG_DEFROST_ON_TEMP        = 3'd4,
        REG_DEFROST_OFF_TEMP       = 3'd5,
        REG_DEFROST_INTERVAL_HOURS = 3'd6,
        REG_DEFROST_MAX_SECONDS    = 3'd7
    } cfg_index_t;

    localparam logic signed [5:0] FRIDGE_SETPOINT_RST  = 6'sd5;
    localparam logic [3:0]        FRIDGE_BAND_RST      = 4'd1;
    localparam logic signed [6:0] FREEZER_SETPOINT_RST = -7'sd24;
    localparam logic [3:0]        FREEZER_BAND_RST     = 4'd1;
    localparam logic signed [5:0] DEFROST_ON_RST       = -6'sd15;
    localparam logic signed [5:0] DEFROST_OFF_RST      = 6'sd5;
    localparam logic [7:0]        INTERVAL_RST         = 8'd24;
    localparam logic [15:0]       MAX_SECONDS_RST      = 16'd7200;
    localparam logic [15:0]       HEATER_SEC_MAX       = 16'hFFFF;

endpackage : ftdc_pkg
`default_nettype wire

/* hw/rtl/fridge_thermostat_defrost_controller_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fridge_thermostat_defrost_controller_core
// Fridge/freezer hysteresis thermostat with timed and temperature defrost.
//
// Each s_ beat is one one-second tick: fridge and freezer temperatures and
// the compressor relay state. Each tick yields exactly one m_ beat with the
// two cooling demands, the heater command and the hours left until a timed
// defrost.
// m_tvalid rises in the cycle after an accepted s_ beat. One tick is taken
// per cycle while the receiver keeps up; the tick's state update and result
// are computed in a single pass of compare and counter logic into the result
// register. When the receiver stalls, the result register holds its beat and
// s_tready stays low only while that register is full and not being taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect on the next tick.
// Reset (aresetn low, synchronous) restores register defaults, clears all
// flags and counters, loads the hour countdown with 24 and empties the
// result register.
// ---------------------------------------------------------------------------
module fridge_thermostat_defrost_controller_core
    import ftdc_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // fridge_temp[7:0], freezer_temp[15:8], compressor_on[16], zero pad
    input  wire [S_TDATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // freezer_demand[0], fridge_demand[1], heater_on[2], hours_left[10:3], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic signed [5:0] fridge_setpoint_reg;
    logic [3:0]        fridge_band_reg;
    logic signed [6:0] freezer_setpoint_reg;
    logic [3:0]        freezer_band_reg;
    logic signed [5:0] defrost_on_reg;
    logic signed [5:0] defrost_off_reg;
    logic [7:0]        interval_reg;
    logic [15:0]       max_seconds_reg;

    logic              freezer_need_reg, freezer_need_next;
    logic              fridge_need_reg, fridge_need_next;
    logic              defrost_need_reg, defrost_need_next;
    logic              heater_reg, heater_next;
    logic [15:0]       heater_sec_reg, heater_sec_next;
    logic [7:0]        hours_reg, hours_next;
    logic [SOH_W-1:0]  soh_reg, soh_next;

    logic              m_valid_reg;
    logic [10:0]       m_data_reg;

    logic              s_beat;
    logic signed [8:0] tf, tz;
    logic signed [8:0] fridge_hi, fridge_lo, freezer_hi, freezer_lo;
    logic signed [8:0] on_thr, off_thr;
    logic              comp;
    logic [SOH_W-1:0]  soh_inc;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-11){1'b0}}, m_data_reg};

    always_comb begin
        tf         = {s_tdata[7], s_tdata[7:0]};
        tz         = {s_tdata[15], s_tdata[15:8]};
        comp       = s_tdata[16];
        fridge_lo  = {{3{fridge_setpoint_reg[5]}}, fridge_setpoint_reg};
        fridge_hi  = fridge_lo + $signed({5'b0, fridge_band_reg});
        freezer_lo = {{2{freezer_setpoint_reg[6]}}, freezer_setpoint_reg};
        freezer_hi = freezer_lo + $signed({5'b0, freezer_band_reg});
        on_thr     = {{3{defrost_on_reg[5]}}, defrost_on_reg};
        off_thr    = {{3{defrost_off_reg[5]}}, defrost_off_reg};

        heater_sec_next = heater_sec_reg;
        if (heater_reg && heater_sec_reg != HEATER_SEC_MAX) begin
            heater_sec_next = heater_sec_reg + 16'd1;
        end

        soh_inc    = soh_reg + SOH_W'(1);
        soh_next   = soh_inc;
        hours_next = hours_reg;
        if (soh_inc >= SECONDS_PER_HOUR) begin
            soh_next = '0;
            if (hours_reg != 8'd0) begin
                hours_next = hours_reg - 8'd1;
            end
        end

        freezer_need_next = freezer_need_reg;
        if (tz > freezer_hi) begin
            freezer_need_next = 1'b1;
        end else if (tz <= freezer_lo) begin
            freezer_need_next = 1'b0;
        end

        fridge_need_next = fridge_need_reg;
        if (tf > fridge_hi) begin
            fridge_need_next = 1'b1;
        end else if (tf <= fridge_lo) begin
            fridge_need_next = 1'b0;
        end

        defrost_need_next = defrost_need_reg;
        if (tf < on_thr) begin
            defrost_need_next = 1'b1;
        end else if (tf >= off_thr) begin
            defrost_need_next = 1'b0;
        end
        if (hours_next == 8'd0) begin
            defrost_need_next = 1'b1;
        end
        if (heater_reg && heater_sec_next > max_seconds_reg) begin
            defrost_need_next = 1'b0;
        end

        heater_next = heater_reg;
        if (defrost_need_next && !comp && !heater_reg) begin
            heater_next     = 1'b1;
            heater_sec_next = '0;
        end
        if (!defrost_need_next && heater_reg) begin
            heater_next = 1'b0;
            hours_next  = interval_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fridge_setpoint_reg  <= FRIDGE_SETPOINT_RST;
            fridge_band_reg      <= FRIDGE_BAND_RST;
            freezer_setpoint_reg <= FREEZER_SETPOINT_RST;
            freezer_band_reg     <= FREEZER_BAND_RST;
            defrost_on_reg       <= DEFROST_ON_RST;
            defrost_off_reg      <= DEFROST_OFF_RST;
            interval_reg         <= INTERVAL_RST;
            max_seconds_reg      <= MAX_SECONDS_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_FRIDGE_SETPOINT:        fridge_setpoint_reg  <= cfg_data[5:0];
                REG_FRIDGE_BAND:            fridge_band_reg      <= cfg_data[3:0];
                REG_FREEZER_SETPOINT:       freezer_setpoint_reg <= cfg_data[6:0];
                REG_FREEZER_BAND:           freezer_band_reg     <= cfg_data[3:0];
                REG_DEFROST_ON_TEMP:        defrost_on_reg       <= cfg_data[5:0];
                REG_DEFROST_OFF_TEMP:       defrost_off_reg      <= cfg_data[5:0];
                REG_DEFROST_INTERVAL_HOURS: interval_reg         <= cfg_data[7:0];
                REG_DEFROST_MAX_SECONDS:    max_seconds_reg      <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freezer_need_reg <= 1'b0;
            fridge_need_reg  <= 1'b0;
            defrost_need_reg <= 1'b0;
            heater_reg       <= 1'b0;
            heater_sec_reg   <= '0;
            hours_reg        <= INTERVAL_RST;
            soh_reg          <= '0;
        end else if (s_beat) begin
            freezer_need_reg <= freezer_need_next;
            fridge_need_reg  <= fridge_need_next;
            defrost_need_reg <= defrost_need_next;
            heater_reg       <= heater_next;
            heater_sec_reg   <= heater_sec_next;
            hours_reg        <= hours_next;
            soh_reg          <= soh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            m_data_reg <= {hours_next, heater_next, fridge_need_next, freezer_need_next};
        end
    end

endmodule : fridge_thermostat_defrost_controller_core
`default_nettype wire
